FILE: sv/bfha_pkg.sv
// shared codes for the best fit heap allocator: commands, status values, register indexes
package bfha_pkg;

  localparam logic [1:0] CMD_ALLOC_BEST = 2'd0;
  localparam logic [1:0] CMD_ALLOC_BACK = 2'd1;
  localparam logic [1:0] CMD_FREE       = 2'd2;
  localparam logic [1:0] CMD_QUERY      = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [2:0] ST_NOT_START = 3'd4;

  localparam logic [1:0] REG_HEAP_BYTES = 2'd0;
  localparam logic [1:0] REG_SEEK_LIMIT = 2'd1;

  localparam logic [7:0] SEEK_RESET = 8'd10;
  localparam logic [15:0] HEAP_BYTES_RESET = 16'd65440;

endpackage

FILE: sv/bfha_ram.sv
// generic simple dual port ram with registered read
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/best_fit_heap_allocator.sv
// best fit heap allocator top level: header store, command sequencer, result register
// an alloc of nonzero size walks the headers backward, then writes the chosen header (on a
//   split also the new free header and the prev link of the header after it); a query walks
//   every block; a free merges with free neighbours; one transaction at a time, one header read per cycle
// reset and each heap_bytes write run a clearing pass over the header ram, during which no
//   transaction is accepted; rst is synchronous, active high
module best_fit_heap_allocator
  import bfha_pkg::*;
#(
  parameter int HEAP_UNITS   = 4096,
  parameter int UNIT_BYTES   = 16,   // power of two
  parameter int HEADER_UNITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_bytes[15:0], block_offset[31:16]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status[2:0], payload_offset[18:3],
                                 // largest_free_bytes[35:19], peak_usage_bytes[52:36]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW    = $clog2(HEAP_UNITS);
  localparam int TW    = AW + 1;
  localparam int XW    = ((TW > 17) ? TW : 17) + 1;
  localparam int SHIFT = $clog2(UNIT_BYTES);
  localparam int MAXB  = (HEAP_UNITS - 2 * HEADER_UNITS) * UNIT_BYTES;

  localparam logic [4:0] S_SWEEP = 5'd0;
  localparam logic [4:0] S_INIT0 = 5'd1;
  localparam logic [4:0] S_INIT1 = 5'd2;
  localparam logic [4:0] S_IDLE  = 5'd3;
  localparam logic [4:0] S_WALK  = 5'd4;
  localparam logic [4:0] S_A_S   = 5'd5;
  localparam logic [4:0] S_A_NB  = 5'd6;
  localparam logic [4:0] S_A_NN  = 5'd7;
  localparam logic [4:0] S_PK_D  = 5'd8;
  localparam logic [4:0] S_PK_L  = 5'd9;
  localparam logic [4:0] S_PK_U  = 5'd10;
  localparam logic [4:0] S_FCHK  = 5'd11;
  localparam logic [4:0] S_FNX   = 5'd12;
  localparam logic [4:0] S_FP    = 5'd13;
  localparam logic [4:0] S_FPCHK = 5'd14;
  localparam logic [4:0] S_FSW   = 5'd15;
  localparam logic [4:0] S_FNXW  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  typedef struct packed {
    logic [TW-1:0] units;
    logic [AW-1:0] prev;
    logic          used;
    logic          present;
  } word_t;

  function automatic logic [TW-1:0] heap_total(input logic [15:0] v);
    logic [31:0] c;
    c = {16'd0, v};
    if (c == 32'd0) c = 32'd1;
    if (c > 32'(MAXB)) c = 32'(MAXB);
    return TW'(((c + 32'(UNIT_BYTES - 1)) >> SHIFT) + 32'(2 * HEADER_UNITS));
  endfunction

  logic [4:0]    state, state_next;
  logic [TW-1:0] total, total_next;
  logic [7:0]    seek, seek_next;
  logic [AW-1:0] sw, sw_next;
  logic [1:0]    cmd, cmd_next;
  logic [XW-1:0] need, need_next;
  logic [AW-1:0] p, p_next;
  logic          found, found_next;
  logic [AW-1:0] best_addr, best_addr_next;
  logic [TW-1:0] fit_units, fit_units_next;
  logic [AW-1:0] best_prev, best_prev_next;
  logic [7:0]    count, count_next;
  logic [AW-1:0] s, s_next;
  word_t         cur, cur_next;
  logic [XW-1:0] nx, nx_next;
  logic          fwd, fwd_next;
  logic          back, back_next;
  logic [2:0]    status, status_next;
  logic [15:0]   pay, pay_next;
  logic [16:0]   big, big_next;
  logic [16:0]   peak, peak_next;
  logic          out_valid, out_valid_next;
  logic [55:0]   out_data, out_data_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  word_t         wdata, rdata;

  bfha_ram #(.WIDTH($bits(word_t)), .DEPTH(HEAP_UNITS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic [TW-1:0] dummy;
  logic [XW-1:0] sz_x, nn_x, u_x;
  logic [31:0]   cand, usage;
  logic          fit, stop;
  logic [7:0]    count_inc, limit;

  assign dummy = total - TW'(HEADER_UNITS);
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    state_next = state;
    total_next = total;
    seek_next = seek;
    sw_next = sw;
    cmd_next = cmd;
    need_next = need;
    p_next = p;
    found_next = found;
    best_addr_next = best_addr;
    fit_units_next = fit_units;
    best_prev_next = best_prev;
    count_next = count;
    s_next = s;
    cur_next = cur;
    nx_next = nx;
    fwd_next = fwd;
    back_next = back;
    status_next = status;
    pay_next = pay;
    big_next = big;
    peak_next = peak;
    out_valid_next = out_valid;
    out_data_next = out_data;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = p;
    sz_x = XW'(rdata.units);
    nn_x = XW'(best_addr) + XW'(fit_units);
    u_x = XW'(s_tdata[31:16] >> SHIFT);
    cand = 32'd0;
    usage = 32'd0;
    fit = 1'b0;
    stop = 1'b0;
    count_inc = (count == 8'hFF) ? count : count + 8'd1;
    limit = (cmd == CMD_ALLOC_BACK) ? 8'd0 : seek;

    if (out_valid && m_tready) out_valid_next = 1'b0;

    unique case (state)
      S_SWEEP: begin
        we = 1'b1;
        waddr = sw;
        sw_next = sw + AW'(1);
        if (sw == AW'(HEAP_UNITS - 1)) state_next = S_INIT0;
      end
      S_INIT0: begin
        we = 1'b1;
        waddr = '0;
        wdata = '{units: dummy, prev: '0, used: 1'b0, present: 1'b1};
        state_next = S_INIT1;
      end
      S_INIT1: begin
        we = 1'b1;
        waddr = dummy[AW-1:0];
        wdata = '{units: '0, prev: '0, used: 1'b0, present: 1'b1};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        raddr = dummy[AW-1:0];
        if (s_tvalid) begin
          cmd_next = s_tuser;
          pay_next = '0;
          big_next = '0;
          status_next = ST_OK;
          p_next = dummy[AW-1:0];
          found_next = 1'b0;
          fit_units_next = '0;
          count_next = '0;
          need_next = XW'((32'(s_tdata[15:0]) + 32'(UNIT_BYTES - 1)) >> SHIFT)
                      + XW'(HEADER_UNITS);
          s_next = AW'(u_x - XW'(HEADER_UNITS));
          unique case (s_tuser)
            CMD_ALLOC_BEST, CMD_ALLOC_BACK: begin
              if (s_tdata[15:0] == 16'd0) begin
                status_next = ST_ZERO_SIZE;
                state_next = S_DONE;
              end else begin
                state_next = S_WALK;
              end
            end
            CMD_FREE: begin
              raddr = AW'(u_x - XW'(HEADER_UNITS));
              if ((s_tdata[16 +: SHIFT] != '0) || (u_x < XW'(HEADER_UNITS)) ||
                  (u_x - XW'(HEADER_UNITS) >= XW'(HEAP_UNITS))) begin
                status_next = ST_NOT_START;
                state_next = S_DONE;
              end else begin
                state_next = S_FCHK;
              end
            end
            default: state_next = S_WALK;
          endcase
        end
      end
      S_WALK: begin
        if (cmd == CMD_QUERY) begin
          cand = (32'(rdata.units) - 32'(HEADER_UNITS)) << SHIFT;
          if (!rdata.used && (32'(rdata.units) >= 32'(HEADER_UNITS)) &&
              (cand > 32'(big))) begin
            big_next = cand[16:0];
          end
          stop = (p == '0);
          if (stop) state_next = S_DONE;
        end else begin
          fit = !rdata.used && (sz_x >= need) && (!found || (rdata.units <= fit_units));
          if (fit) begin
            best_addr_next = p;
            fit_units_next = rdata.units;
            best_prev_next = rdata.prev;
          end
          found_next = found || fit;
          count_next = count_inc;
          stop = ((found || fit) && (count_inc >= limit)) || (p == '0);
          if (stop) begin
            if (found || fit) begin
              state_next = S_A_S;
            end else begin
              status_next = ST_NO_SPACE;
              state_next = S_DONE;
            end
          end
        end
        if (!stop) begin
          raddr = rdata.prev;
          p_next = rdata.prev;
        end
      end
      S_A_S: begin
        we = 1'b1;
        waddr = best_addr;
        pay_next = 16'((32'(best_addr) + 32'(HEADER_UNITS)) << SHIFT);
        // split only if the remainder is larger than one header
        if (XW'(fit_units) > need + XW'(HEADER_UNITS)) begin
          wdata = '{units: TW'(need), prev: best_prev, used: 1'b1, present: 1'b1};
          state_next = S_A_NB;
        end else begin
          wdata = '{units: fit_units, prev: best_prev, used: 1'b1, present: 1'b1};
          state_next = S_PK_D;
        end
      end
      S_A_NB: begin
        we = 1'b1;
        waddr = AW'(XW'(best_addr) + need);
        wdata = '{units: TW'(XW'(fit_units) - need), prev: best_addr,
                  used: 1'b0, present: 1'b1};
        raddr = nn_x[AW-1:0];
        state_next = (nn_x < XW'(HEAP_UNITS)) ? S_A_NN : S_PK_D;
      end
      S_A_NN: begin
        we = 1'b1;
        waddr = nn_x[AW-1:0];
        wdata = rdata;
        wdata.prev = AW'(XW'(best_addr) + need);
        state_next = S_PK_D;
      end
      S_PK_D: begin
        raddr = dummy[AW-1:0];
        state_next = S_PK_L;
      end
      S_PK_L: begin
        raddr = rdata.prev;
        state_next = S_PK_U;
      end
      S_PK_U: begin
        usage = 32'(total) << SHIFT;
        if (!rdata.used && (32'(rdata.units) > 32'(HEADER_UNITS))) begin
          usage = usage - ((32'(rdata.units) - 32'(HEADER_UNITS)) << SHIFT);
        end
        if (usage > 32'(peak)) peak_next = usage[16:0];
        state_next = S_DONE;
      end
      S_FCHK: begin
        nx_next = XW'(s) + XW'(rdata.units);
        fwd_next = 1'b0;
        back_next = 1'b0;
        cur_next = rdata;
        cur_next.used = 1'b0;
        raddr = AW'(XW'(s) + XW'(rdata.units));
        if (!rdata.present) begin
          status_next = ST_NOT_START;
          state_next = S_DONE;
        end else if (!rdata.used) begin
          status_next = ST_NOT_ALLOC;
          state_next = S_DONE;
        end else begin
          state_next = (XW'(s) + XW'(rdata.units) < XW'(HEAP_UNITS)) ? S_FNX : S_FP;
        end
      end
      S_FNX: begin
        // merge with the following block when it is free and not the dummy
        if (!rdata.used && (rdata.units != '0)) begin
          we = 1'b1;
          waddr = nx[AW-1:0];
          wdata = rdata;
          wdata.units = '0;
          wdata.present = 1'b0;
          cur_next.units = cur.units + rdata.units;
          nx_next = XW'(s) + XW'(cur.units + rdata.units);
          fwd_next = 1'b1;
        end
        state_next = S_FP;
      end
      S_FP: begin
        raddr = cur.prev;
        state_next = (s == '0) ? S_FSW : S_FPCHK;
      end
      S_FPCHK: begin
        if (!rdata.used) begin
          we = 1'b1;
          waddr = cur.prev;
          wdata = rdata;
          wdata.units = rdata.units + cur.units;
          back_next = 1'b1;
        end
        state_next = S_FSW;
      end
      S_FSW: begin
        we = 1'b1;
        waddr = s;
        wdata = cur;
        if (back) begin
          wdata.units = '0;
          wdata.present = 1'b0;
        end
        raddr = nx[AW-1:0];
        state_next = ((fwd || back) && (nx < XW'(HEAP_UNITS))) ? S_FNXW : S_DONE;
      end
      S_FNXW: begin
        we = 1'b1;
        waddr = nx[AW-1:0];
        wdata = rdata;
        wdata.prev = back ? cur.prev : s;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next = {3'd0, peak, big, pay, status};
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cfg_we) begin
      priority if (cfg_index == REG_HEAP_BYTES) begin
        total_next = heap_total(cfg_data);
        peak_next = '0;
        sw_next = '0;
        state_next = S_SWEEP;
      end else if (cfg_index == REG_SEEK_LIMIT) begin
        seek_next = cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      total <= heap_total(HEAP_BYTES_RESET);
      seek <= SEEK_RESET;
      sw <= '0;
      peak <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      seek <= seek_next;
      sw <= sw_next;
      peak <= peak_next;
      out_valid <= out_valid_next;
    end
    cmd <= cmd_next;
    need <= need_next;
    p <= p_next;
    found <= found_next;
    best_addr <= best_addr_next;
    fit_units <= fit_units_next;
    best_prev <= best_prev_next;
    count <= count_next;
    s <= s_next;
    cur <= cur_next;
    nx <= nx_next;
    fwd <= fwd_next;
    back <= back_next;
    status <= status_next;
    pay <= pay_next;
    big <= big_next;
    out_data <= out_data_next;
  end

`ifndef SYNTHESIS
  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(cfg_we && (cfg_index == REG_HEAP_BYTES)) |=> (peak >= $past(peak)))
    else $error("peak usage decreased without a heap reinit");

  a_walk_not_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (cmd != CMD_FREE))
    else $error("backward walk entered for a free transaction");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !cfg_we) |=> (state != S_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result appeared outside the done state");
`endif

endmodule
